>>> design/ccs_pkg.sv
// Package: shared types, constants and fixed-point helpers for the capacitor stamp.
`default_nettype none
package ccs_pkg;
  localparam int unsigned DEVICES = 256;
  localparam int unsigned NODES = 1024;
  localparam int unsigned DEV_W = 8;
  localparam int unsigned NODE_W = 11;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned Q_W = 48;
  localparam int unsigned HIST_W = 3 * Q_W;

  localparam logic [2:0] REG_COEF_ZERO = 3'd0;
  localparam logic [2:0] REG_COEF_ONE = 3'd1;
  localparam logic [2:0] REG_COEF_TWO = 3'd2;
  localparam logic [2:0] REG_INV_STEP = 3'd3;
  localparam logic [2:0] REG_USE_SECOND = 3'd4;
  localparam logic [2:0] REG_TRAP = 3'd5;

  localparam logic CMD_STAMP = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;
  localparam logic TGT_MATRIX = 1'b0;
  localparam logic TGT_RHS = 1'b1;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MUL1, ST_MUL2, ST_MUL3, ST_SUM, ST_EMIT
  } ccs_state_t;

  typedef struct packed {
    logic signed [Q_W-1:0] v;
    logic signed [Q_W-1:0] v2;
    logic signed [Q_W-1:0] i;
  } hist_t;

  typedef struct packed {
    logic                  rd_en;
    logic [DEV_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [DEV_W-1:0]      wr_addr;
    hist_t                 wr_data;
  } mem_ctl_t;

  // Saturate a wide signed value to Q24.24.
  function automatic logic signed [Q_W-1:0] sat49(input logic signed [Q_W:0] x);
    if (x > $signed({1'b0, Q_MAX})) return Q_MAX;
    if (x < $signed({1'b1, Q_MIN})) return Q_MIN;
    return x[Q_W-1:0];
  endfunction

  // Sign-magnitude product rounding: magnitude (96 bits) shifted by s,
  // rounded half away from zero, then signed saturation.
  function automatic logic signed [Q_W-1:0] rnd_sat(input logic neg,
      input logic [95:0] mag, input logic [4:0] s);
    logic [96:0] r;
    logic [96:0] q;
    r = {1'b0, mag} + (97'd1 << (s - 5'd1));
    q = r >> s;
    if (neg) begin
      if (q > 97'h800000000000) return Q_MIN;
      return -$signed(q[Q_W-1:0]);
    end
    if (q > 97'h7FFFFFFFFFFF) return Q_MAX;
    return q[Q_W-1:0];
  endfunction

  function automatic logic [Q_W-1:0] mag48(input logic signed [Q_W-1:0] a);
    return a[Q_W-1] ? (~a + 1'b1) : a;
  endfunction
endpackage
`default_nettype wire

>>> design/ccs_hist_ram.sv
// History table: one synchronous RAM, registered read, one write port.
`default_nettype none
module ccs_hist_ram (
  input  wire logic               clk,
  input  wire ccs_pkg::mem_ctl_t  ctl,
  output ccs_pkg::hist_t          rd_data
);
  import ccs_pkg::*;
  hist_t mem [DEVICES];
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end
endmodule
`default_nettype wire

>>> design/ccs_mul.sv
// Registered 48x48 sign-magnitude multiplier: four 24x24 partial products per cycle go
// to a first register, then rounding shift and saturation into the output register.
`default_nettype none
module ccs_mul (
  input  wire logic                              clk,
  input  wire logic signed [ccs_pkg::Q_W-1:0]    a,
  input  wire logic signed [ccs_pkg::Q_W-1:0]    b,
  input  wire logic [4:0]                        shift,
  output logic signed [ccs_pkg::Q_W-1:0]         p
);
  import ccs_pkg::*;
  logic [Q_W-1:0] ma, mb;
  logic [47:0] pp0, pp1, pp2, pp3;
  logic neg_q;
  logic [4:0] sh_q;
  logic [95:0] mag;
  always_comb begin
    ma = mag48(a);
    mb = mag48(b);
    mag = {48'd0, pp0} + ({48'd0, pp1} << 24) + ({48'd0, pp2} << 24)
          + ({48'd0, pp3} << 48);
  end
  always_ff @(posedge clk) begin
    pp0 <= ma[23:0] * mb[23:0];
    pp1 <= ma[47:24] * mb[23:0];
    pp2 <= ma[23:0] * mb[47:24];
    pp3 <= ma[47:24] * mb[47:24];
    neg_q <= a[Q_W-1] ^ b[Q_W-1];
    sh_q <= shift;
    p <= rnd_sat(neg_q, mag, sh_q);
  end
endmodule
`default_nettype wire

>>> design/capacitor_companion_stamp.sv
// Top level: capacitor companion-model stamp with per-device history table.
// Each request is taken in ST_IDLE and handled alone. The device history
// (previous voltage, the voltage before it, previous current) lives in one
// 256-entry synchronous RAM; a request reads its entry, computes through a
// single shared registered multiplier, and an update writes the entry
// back. Since only one request is in flight, reads always see prior writes.
// A stamp reads its entry, forms the coefficient products, then the
// previous-voltage term, then the older-voltage term when the second history
// point is enabled, then the sum, and then emits one contribution per cycle
// (up to six) while out_ready is high. An update reads its entry, passes a
// setup step, which in trapezoidal mode also waits for its product, and writes
// back. Every request returns to ST_IDLE before the next one is taken. After
// reset a clearing pass zeroes all 256 table entries while requests are held off;
// configuration writes are always accepted but should only be issued while no
// request is in flight. Values are Q24.24 and saturate; grounded nodes
// (negative index) are skipped.
`default_nettype none
module capacitor_companion_stamp (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [7:0]  device_index,
  input  wire logic signed [10:0] node_a,
  input  wire logic signed [10:0] node_b,
  input  wire logic [31:0] capacitance,
  input  wire logic signed [47:0] voltage_a,
  input  wire logic signed [47:0] voltage_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             target,
  output logic [9:0]       row,
  output logic [9:0]       column,
  output logic signed [47:0] value,
  output logic             last
);
  import ccs_pkg::*;

  // configuration registers
  logic signed [23:0] coef_zero, coef_one, coef_two;
  logic [31:0] inv_step;
  logic use_second, trap;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_zero <= 24'sd65536;
      coef_one <= -24'sd65536;
      coef_two <= '0;
      inv_step <= 32'd1;
      use_second <= 1'b0;
      trap <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COEF_ZERO: coef_zero <= cfg_data[23:0];
        REG_COEF_ONE: coef_one <= cfg_data[23:0];
        REG_COEF_TWO: coef_two <= cfg_data[23:0];
        REG_INV_STEP: inv_step <= cfg_data;
        REG_USE_SECOND: use_second <= cfg_data[0];
        REG_TRAP: trap <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  logic clearing;
  logic [DEV_W:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (DEV_W+1)'(DEVICES - 1)) clearing <= 1'b0;
    end
  end

  // request registers
  ccs_state_t state, state_next;
  logic req_cmd;
  logic [DEV_W-1:0] dev;
  logic [IDX_W-1:0] na, nb;
  logic ga, gb;
  logic [31:0] cap;
  logic signed [Q_W-1:0] va, vb;
  logic [3:0] cnt;
  logic [2:0] slot;
  logic [5:0] emit_mask;

  logic in_fire;
  assign in_ready = (state == ST_IDLE) && !clearing;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_cmd <= cmd;
      dev <= device_index;
      na <= node_a[IDX_W-1:0];
      nb <= node_b[IDX_W-1:0];
      ga <= node_a[NODE_W-1];
      gb <= node_b[NODE_W-1];
      cap <= capacitance;
      va <= voltage_a;
      vb <= voltage_b;
    end
  end

  // history RAM
  mem_ctl_t mctl;
  hist_t hist_rd, hist;
  ccs_hist_ram u_ram (.clk(clk), .ctl(mctl), .rd_data(hist_rd));

  // shared multiplier
  logic signed [Q_W-1:0] mul_a, mul_b, mul_p;
  logic [4:0] mul_s;
  ccs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .shift(mul_s), .p(mul_p));

  // arithmetic registers
  logic signed [Q_W-1:0] coh, g, k1, k2, t1, t2, ieq, vnew;
  logic signed [Q_W-1:0] hist_sum;
  logic [63:0] coh_full;
  assign coh_full = {32'd0, cap} * {32'd0, inv_step};

  // voltage terms saturate before the trapezoidal current is added
  assign hist_sum = sat49($signed({t1[Q_W-1], t1}) + $signed({t2[Q_W-1], t2}));

  // sequencer counter: operand schedule through the registered multiplier
  // issue at cnt 0: coef0*coh, 1: coef1*coh, 2: coef2*coh; results come from its
  // output register (update: 2coh*dv issued and held from cnt 0)
  always_comb begin
    mul_a = '0;
    mul_b = coh;
    mul_s = 5'd16;
    unique case (state)
      ST_MUL1: begin
        mul_b = coh;
        mul_s = 5'd16;
        if (req_cmd == CMD_UPDATE) begin
          mul_a = sat49({coh[Q_W-1], coh} <<< 1);
          mul_b = sat49($signed({vnew[Q_W-1], vnew}) - $signed({hist.v[Q_W-1], hist.v}));
          mul_s = 5'd24;
        end else if (cnt == 4'd0) mul_a = Q_W'(coef_zero);
        else if (cnt == 4'd1) mul_a = Q_W'(coef_one);
        else mul_a = Q_W'(coef_two);
      end
      ST_MUL2: begin
        mul_a = k1;
        mul_b = hist.v;
        mul_s = 5'd24;
      end
      ST_MUL3: begin
        mul_a = k2;
        mul_b = hist.v2;
        mul_s = 5'd24;
      end
      default: ;
    endcase
  end

  // slot validity: aa, bb, ab, ba, rhs a, rhs b
  logic [5:0] slots_all;
  assign slots_all = {!gb, !ga, !ga && !gb, !ga && !gb, !gb, !ga};

  logic slot_end;
  logic [5:0] rem_mask;
  always_comb begin
    rem_mask = emit_mask & ~(6'b1 << slot);
    slot_end = (rem_mask & ~((6'b1 << slot) - 6'b1)) == '0;
  end

  // lowest pending slot, for the first contribution and for the next one
  logic [2:0] first_all, first_rem;
  always_comb begin
    first_all = '0;
    first_rem = '0;
    for (int j = 5; j >= 0; j--) begin
      if (slots_all[j]) first_all = 3'(j);
      if (rem_mask[j]) first_rem = 3'(j);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = ST_READ;
      ST_READ: if (cnt == 4'd1) state_next = ST_MUL1;
      ST_MUL1: begin
        if (req_cmd == CMD_UPDATE) begin
          if (!trap || cnt == 4'd3) state_next = ST_SUM;
        end else if (cnt == 4'd4) state_next = ST_MUL2;
      end
      ST_MUL2: if (cnt == 4'd3) state_next = use_second ? ST_MUL3 : ST_SUM;
      ST_MUL3: if (cnt == 4'd3) state_next = ST_SUM;
      ST_SUM: begin
        if (req_cmd == CMD_UPDATE) state_next = ST_IDLE;
        else if (slots_all == '0) state_next = ST_IDLE;
        else state_next = ST_EMIT;
      end
      ST_EMIT: if (out_ready && slot_end) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    mctl.rd_en = (state == ST_READ) && (cnt == 4'd0);
    mctl.rd_addr = dev;
    mctl.wr_en = clearing;
    mctl.wr_addr = clr_cnt[DEV_W-1:0];
    mctl.wr_data = '0;
    if (state == ST_SUM && req_cmd == CMD_UPDATE) begin
      mctl.wr_en = 1'b1;
      mctl.wr_addr = dev;
      mctl.wr_data.v = vnew;
      mctl.wr_data.v2 = hist.v;
      mctl.wr_data.i = trap
        ? sat49($signed({t1[Q_W-1], t1}) - $signed({hist.i[Q_W-1], hist.i}))
        : hist.i;
    end
  end

  // datapath registers
  logic signed [Q_W-1:0] vav, vbv;
  always_comb begin
    vav = ga ? '0 : va;
    vbv = gb ? '0 : vb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      slot <= '0;
      emit_mask <= '0;
    end else begin
      state <= state_next;
      cnt <= (state_next != state) ? 4'd0 : cnt + 4'd1;
      if (state == ST_SUM) begin
        emit_mask <= slots_all;
        slot <= first_all;
      end else if (state == ST_EMIT && out_ready) begin
        emit_mask <= rem_mask;
        slot <= first_rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      coh <= (coh_full > 64'h7FFFFFFFFFFF) ? Q_MAX : coh_full[Q_W-1:0];
      vnew <= sat49($signed({vav[Q_W-1], vav}) - $signed({vbv[Q_W-1], vbv}));
      t2 <= '0;
    end
    if (state == ST_READ && cnt == 4'd1) hist <= hist_rd;
    if (state == ST_MUL1) begin
      if (req_cmd == CMD_UPDATE) begin
        if (cnt == 4'd3) t1 <= mul_p;
      end else begin
        if (cnt == 4'd2) g <= mul_p;
        if (cnt == 4'd3) k1 <= mul_p;
        if (cnt == 4'd4) k2 <= mul_p;
      end
    end
    if (state == ST_MUL2 && cnt == 4'd3) t1 <= mul_p;
    if (state == ST_MUL3 && cnt == 4'd3) t2 <= mul_p;
    if (state == ST_SUM && req_cmd == CMD_STAMP) begin
      ieq <= sat49($signed({hist_sum[Q_W-1], hist_sum})
                   + (trap ? $signed({hist.i[Q_W-1], hist.i}) : 49'sd0));
    end
  end

  // output mux
  always_comb begin
    out_valid = (state == ST_EMIT);
    target = TGT_MATRIX;
    row = na;
    column = na;
    value = g;
    last = slot_end;
    unique case (slot)
      3'd0: begin row = na; column = na; value = g; end
      3'd1: begin row = nb; column = nb; value = g; end
      3'd2: begin row = na; column = nb; value = sat49(-$signed({g[Q_W-1], g})); end
      3'd3: begin row = nb; column = na; value = sat49(-$signed({g[Q_W-1], g})); end
      3'd4: begin
        target = TGT_RHS; row = na; column = '0;
        value = sat49(-$signed({ieq[Q_W-1], ieq}));
      end
      3'd5: begin target = TGT_RHS; row = nb; column = '0; value = ieq; end
      default: ;
    endcase
  end

  // checks
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_no_out_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_valid) else $error("output during clear");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(slot))
    else $error("emit slot changed under stall");
endmodule
`default_nettype wire
